/* hw/rtl/kpp_pkg.sv */
package kpp_pkg;

  localparam int EnergyW   = 38;
  localparam int TotalW    = 48;
  localparam int FracW     = 16;
  localparam int ProdW     = TotalW + FracW;
  localparam int OutCoordW = 16;
  localparam int IdxW      = 10;
  localparam int DimW      = 4;
  localparam int DoneW     = 11;
  localparam int CfgW      = 11;
  localparam int DataW     = 48;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_FIRST = 2'd1,
    FN_DRAW  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    RS_LOADED   = 2'd0,
    RS_CENTER   = 2'd1,
    RS_REJECTED = 2'd2,
    RS_IGNORED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_NUM_POINTS  = 2'd0,
    CFG_NUM_DIMS    = 2'd1,
    CFG_NUM_CENTERS = 2'd2
  } cfg_e;

  // tag that travels with one coordinate through the distance pipeline
  typedef struct packed {
    logic vld;
    logic lst;
  } kpp_ctl_t;

endpackage

/* hw/rtl/kpp_dist.sv */
module kpp_dist import kpp_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int PW         = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kpp_ctl_t              ctl_i,
  input  logic [PW-1:0]         j_i,
  input  logic [COORD_BITS-1:0] coord_i,
  input  logic [COORD_BITS-1:0] ctr_i,
  output kpp_ctl_t              pre_ctl_o,
  output logic [PW-1:0]         pre_j_o,
  output kpp_ctl_t              res_ctl_o,
  output logic [PW-1:0]         res_j_o,
  output logic [EnergyW-1:0]    dist_o
);

  localparam int SqW = 2 * COORD_BITS + 2;

  kpp_ctl_t                   b_ctl_q, c_ctl_q;
  logic [PW-1:0]              b_j_q, c_j_q;
  logic signed [COORD_BITS:0] diff_q;
  logic [SqW-1:0]             sq_q;
  logic [EnergyW-1:0]         acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_ctl_q <= '0;
      c_ctl_q <= '0;
      acc_q   <= '0;
    end else begin
      b_ctl_q <= ctl_i;
      c_ctl_q <= b_ctl_q;
      if (c_ctl_q.vld) begin
        acc_q <= c_ctl_q.lst ? '0 : dist_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_j_q  <= j_i;
    c_j_q  <= b_j_q;
    diff_q <= $signed({coord_i[COORD_BITS-1], coord_i}) - $signed({ctr_i[COORD_BITS-1], ctr_i});
    sq_q   <= SqW'(diff_q * diff_q);
  end

  assign dist_o    = acc_q + EnergyW'(sq_q);
  assign pre_ctl_o = b_ctl_q;
  assign pre_j_o   = b_j_q;
  assign res_ctl_o = c_ctl_q;
  assign res_j_o   = c_j_q;

endmodule

/* hw/rtl/kmeans_plusplus_seeding.sv */
// k-means++ seed picker
// configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 points in use,
//   1 coordinates per point, 2 centres to place); write only while the block is idle
// input stream: one beat per command; tuser is the function code, tdata carries the
//   point index, coordinate position, coordinate value and draw fraction
// output stream: a load, an ignored command or a rejected draw gives one beat; a placed
//   centre gives one beat per coordinate, tlast on the final one
// after reset all MAX_POINTS chosen marks are swept clear, one point a cycle,
//   with s_axis_tready low
// a first centre sweeps the chosen marks, setting only its own, loads the centre
//   coordinates, runs the distance sweep over every point in use and emits the centre;
//   a draw scans the energies, checks the mark, then loads, sweeps and emits, or gives a
//   rejection beat; the distance sweep reads the point store one coordinate a cycle
// input is taken only in idle with the output register free or draining; a stalled
//   receiver holds the current beat and pauses the emission of further coordinates
module kmeans_plusplus_seeding import kpp_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_DIMS   = 16,
  parameter int COORD_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // point_index, dim_index, coord_value, draw_fraction, zero pad
  input  logic [DataW-1:0] s_axis_tdata,
  // func
  input  logic [1:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // chosen_index, center_dim, center_value, centers_done, zero pad
  output logic [DataW-1:0] m_axis_tdata,
  // status
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int PW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int AW  = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int CB  = COORD_BITS;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_MUL, ST_SCAN, ST_MCHK, ST_REJ, ST_LOADC, ST_SWEEP, ST_EMIT
  } state_e;

  // memories
  logic [CB-1:0]      pstore [MAX_POINTS*MAX_DIMS];
  logic [EnergyW-1:0] estore [MAX_POINTS];
  logic               mstore [MAX_POINTS];

  logic [CB-1:0]      pst_rd_q, pst_wdata;
  logic [EnergyW-1:0] est_rd_q, est_wdata;
  logic               mk_rd_q, mk_wdata;
  logic               pst_we, pst_re, est_we, est_re, mk_we, mk_re;
  logic [AW-1:0]      pst_waddr, pst_raddr;
  logic [PW-1:0]      est_waddr, est_raddr, mk_waddr, mk_raddr, rd_pt;

  // control state
  state_e             st_q;
  logic [CfgW-1:0]    npts_q, ncen_q;
  logic [4:0]         ndim_q;
  logic [PW-1:0]      j_q, c_q, rj_q, a_j_q;
  logic [DW-1:0]      t_q, ld_t_q, a_t_q;
  logic               iss_q, set_q, first_q, rv_q, ld_v_q;
  logic [FracW-1:0]   frac_q;
  logic [ProdW-1:0]   thresh_q;
  logic [TotalW-1:0]  run_q, tot_q;
  logic [DoneW-1:0]   centers_q;
  kpp_ctl_t           a_ctl_q;
  logic [CB-1:0]      ctr_q [MAX_DIMS];

  // output register
  logic                 o_v_q, o_last_q;
  status_e              o_st_q;
  logic [IdxW-1:0]      o_idx_q;
  logic [DimW-1:0]      o_dim_q;
  logic [OutCoordW-1:0] o_val_q;
  logic [DoneW-1:0]     o_done_q;

  // input fields
  func_e              in_func;
  logic [IdxW-1:0]    in_pidx;
  logic [DimW-1:0]    in_didx;
  logic signed [15:0] in_cval;
  logic [FracW-1:0]   in_frac;
  logic [CB-1:0]      ld_coord;
  logic               in_acc, out_free;

  // effective configuration
  logic [NW-1:0]      n_eff;
  logic [PW-1:0]      n_last;
  logic [DCW-1:0]     d_eff;
  logic [DW-1:0]      d_last;
  logic [CfgW-1:0]    kc;
  logic               load_ok, first_ok, draw_ok;

  // scan and sweep datapath
  logic [TotalW-1:0]  run_nx;
  logic               scan_hit;
  kpp_ctl_t           pre_ctl, res_ctl;
  logic [PW-1:0]      pre_j, res_j;
  logic [EnergyW-1:0] dist_sum, e_new;
  logic               sweep_end;

  assign in_func  = func_e'(s_axis_tuser);
  assign in_pidx  = s_axis_tdata[9:0];
  assign in_didx  = s_axis_tdata[13:10];
  assign in_cval  = s_axis_tdata[29:14];
  assign in_frac  = s_axis_tdata[45:30];
  assign ld_coord = CB'(in_cval);

  assign out_free      = !o_v_q || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (npts_q == '0) n_eff = NW'(1);
    else if (32'(npts_q) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
    else n_eff = NW'(npts_q);
    if (ndim_q == '0) d_eff = DCW'(1);
    else if (32'(ndim_q) > MAX_DIMS) d_eff = DCW'(MAX_DIMS);
    else d_eff = DCW'(ndim_q);
  end

  assign n_last   = PW'(n_eff - NW'(1));
  assign d_last   = DW'(d_eff - DCW'(1));
  assign kc       = (ncen_q == '0) ? CfgW'(1) : ncen_q;
  assign load_ok  = (32'(in_pidx) < MAX_POINTS) && (32'(in_didx) < MAX_DIMS);
  assign first_ok = 32'(in_pidx) < 32'(n_eff);
  assign draw_ok  = (centers_q != '0) && (centers_q < kc);

  // running sum reaches fraction times total, last point in use as fallback
  assign run_nx   = run_q + TotalW'(est_rd_q);
  assign scan_hit = (st_q == ST_SCAN) && rv_q
                    && (({run_nx, 16'b0} >= thresh_q) || (rj_q == n_last));

  kpp_dist #(
    .COORD_BITS (CB),
    .PW         (PW)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (a_ctl_q),
    .j_i       (a_j_q),
    .coord_i   (pst_rd_q),
    .ctr_i     (ctr_q[a_t_q]),
    .pre_ctl_o (pre_ctl),
    .pre_j_o   (pre_j),
    .res_ctl_o (res_ctl),
    .res_j_o   (res_j),
    .dist_o    (dist_sum)
  );

  // the first centre overwrites, later centres lower energies
  assign e_new     = (first_q || (dist_sum < est_rd_q)) ? dist_sum : est_rd_q;
  assign sweep_end = (st_q == ST_SWEEP) && res_ctl.vld && res_ctl.lst && (res_j == n_last);

  // memory port steering
  always_comb begin
    rd_pt     = (st_q == ST_LOADC) ? c_q : j_q;
    pst_we    = in_acc && (in_func == FN_LOAD) && load_ok;
    pst_waddr = AW'(32'(PW'(in_pidx)) * MAX_DIMS + 32'(in_didx));
    pst_wdata = ld_coord;
    pst_re    = iss_q && ((st_q == ST_LOADC) || (st_q == ST_SWEEP));
    pst_raddr = AW'(32'(rd_pt) * MAX_DIMS + 32'(t_q));

    est_re    = (iss_q && (st_q == ST_SCAN)) || (pre_ctl.vld && pre_ctl.lst);
    est_raddr = (st_q == ST_SCAN) ? j_q : pre_j;
    est_we    = (st_q == ST_SWEEP) && res_ctl.vld && res_ctl.lst;
    est_waddr = res_j;
    est_wdata = e_new;

    mk_re     = scan_hit;
    mk_raddr  = rj_q;
    mk_we     = (st_q == ST_CLR) || ((st_q == ST_MCHK) && !mk_rd_q);
    mk_waddr  = (st_q == ST_CLR) ? j_q : c_q;
    mk_wdata  = (st_q == ST_CLR) ? (set_q && (j_q == c_q)) : 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (pst_we) pstore[pst_waddr] <= pst_wdata;
    if (pst_re) pst_rd_q <= pstore[pst_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (est_we) estore[est_waddr] <= est_wdata;
    if (est_re) est_rd_q <= estore[est_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mk_we) mstore[mk_waddr] <= mk_wdata;
    if (mk_re) mk_rd_q <= mstore[mk_raddr];
  end

  // centre coordinates captured from the point store read register pst_rd_q
  always_ff @(posedge clk_i) begin
    if (ld_v_q) ctr_q[ld_t_q] <= pst_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLR;
      npts_q    <= 11'd1024;
      ndim_q    <= 5'd16;
      ncen_q    <= 11'd8;
      j_q       <= '0;
      t_q       <= '0;
      c_q       <= '0;
      rj_q      <= '0;
      iss_q     <= 1'b0;
      set_q     <= 1'b0;
      first_q   <= 1'b0;
      rv_q      <= 1'b0;
      ld_v_q    <= 1'b0;
      ld_t_q    <= '0;
      frac_q    <= '0;
      thresh_q  <= '0;
      run_q     <= '0;
      tot_q     <= '0;
      centers_q <= '0;
      a_ctl_q   <= '0;
      a_j_q     <= '0;
      a_t_q     <= '0;
      o_v_q     <= 1'b0;
      o_last_q  <= 1'b0;
      o_st_q    <= RS_IGNORED;
      o_idx_q   <= '0;
      o_dim_q   <= '0;
      o_val_q   <= '0;
      o_done_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_NUM_POINTS:  npts_q <= cfg_data_i;
          CFG_NUM_DIMS:    ndim_q <= cfg_data_i[4:0];
          CFG_NUM_CENTERS: ncen_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (m_axis_tready) o_v_q <= 1'b0;

      // distance pipeline feed, registered alongside the point store read data
      a_ctl_q.vld <= (st_q == ST_SWEEP) && iss_q;
      a_ctl_q.lst <= (t_q == d_last);
      a_j_q       <= j_q;
      a_t_q       <= t_q;
      ld_v_q      <= (st_q == ST_LOADC) && iss_q;
      ld_t_q      <= t_q;

      unique case (st_q)
        ST_CLR: begin
          if (j_q == PW'(MAX_POINTS - 1)) begin
            j_q <= '0;
            if (set_q) begin
              st_q  <= ST_LOADC;
              t_q   <= '0;
              iss_q <= 1'b1;
            end else begin
              st_q <= ST_IDLE;
            end
            set_q <= 1'b0;
          end else begin
            j_q <= j_q + PW'(1);
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            o_v_q    <= 1'b1;
            o_last_q <= 1'b1;
            o_st_q   <= RS_IGNORED;
            o_idx_q  <= '0;
            o_dim_q  <= '0;
            o_val_q  <= '0;
            o_done_q <= centers_q;
            unique case (in_func)
              FN_LOAD: begin
                if (load_ok) begin
                  o_st_q  <= RS_LOADED;
                  o_idx_q <= in_pidx;
                  o_dim_q <= in_didx;
                  o_val_q <= OutCoordW'(ld_coord);
                end
              end
              FN_FIRST: begin
                if (first_ok) begin
                  o_v_q   <= 1'b0;
                  c_q     <= PW'(in_pidx);
                  set_q   <= 1'b1;
                  first_q <= 1'b1;
                  j_q     <= '0;
                  st_q    <= ST_CLR;
                end
              end
              FN_DRAW: begin
                if (draw_ok) begin
                  o_v_q   <= 1'b0;
                  frac_q  <= in_frac;
                  first_q <= 1'b0;
                  st_q    <= ST_MUL;
                end
              end
              default: ;
            endcase
          end
        end

        ST_MUL: begin
          thresh_q <= frac_q * tot_q;
          run_q    <= '0;
          j_q      <= '0;
          iss_q    <= 1'b1;
          rv_q     <= 1'b0;
          st_q     <= ST_SCAN;
        end

        ST_SCAN: begin
          rv_q <= iss_q;
          rj_q <= j_q;
          if (iss_q) begin
            if (j_q == n_last) iss_q <= 1'b0;
            else j_q <= j_q + PW'(1);
          end
          if (rv_q) run_q <= run_nx;
          if (scan_hit) begin
            c_q   <= rj_q;
            iss_q <= 1'b0;
            rv_q  <= 1'b0;
            st_q  <= ST_MCHK;
          end
        end

        ST_MCHK: begin
          if (mk_rd_q) begin
            st_q <= ST_REJ;
          end else begin
            t_q   <= '0;
            iss_q <= 1'b1;
            st_q  <= ST_LOADC;
          end
        end

        ST_REJ: begin
          if (out_free) begin
            o_v_q    <= 1'b1;
            o_last_q <= 1'b1;
            o_st_q   <= RS_REJECTED;
            o_idx_q  <= IdxW'(c_q);
            o_dim_q  <= '0;
            o_val_q  <= '0;
            o_done_q <= centers_q;
            st_q     <= ST_IDLE;
          end
        end

        ST_LOADC: begin
          if (iss_q) begin
            if (t_q == d_last) iss_q <= 1'b0;
            else t_q <= t_q + DW'(1);
          end
          if (ld_v_q && (ld_t_q == d_last)) begin
            j_q   <= '0;
            t_q   <= '0;
            iss_q <= 1'b1;
            tot_q <= '0;
            st_q  <= ST_SWEEP;
          end
        end

        ST_SWEEP: begin
          if (iss_q) begin
            if (t_q == d_last) begin
              t_q <= '0;
              if (j_q == n_last) iss_q <= 1'b0;
              else j_q <= j_q + PW'(1);
            end else begin
              t_q <= t_q + DW'(1);
            end
          end
          if (res_ctl.vld && res_ctl.lst) tot_q <= tot_q + TotalW'(e_new);
          if (sweep_end) begin
            centers_q <= first_q ? DoneW'(1) : centers_q + DoneW'(1);
            t_q       <= '0;
            st_q      <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            o_v_q    <= 1'b1;
            o_last_q <= (t_q == d_last);
            o_st_q   <= RS_CENTER;
            o_idx_q  <= IdxW'(c_q);
            o_dim_q  <= DimW'(t_q);
            o_val_q  <= OutCoordW'(ctr_q[t_q]);
            o_done_q <= centers_q;
            if (t_q == d_last) st_q <= ST_IDLE;
            else t_q <= t_q + DW'(1);
          end
        end

        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tuser  = o_st_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {7'b0, o_done_q, o_val_q, o_dim_q, o_idx_q};

  // energies are written only by the distance sweep
  a_est_sweep_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    est_we |-> (st_q == ST_SWEEP))
    else $error("energy write outside sweep");

  // a new beat only comes from idle, a rejection or the coordinate emission
  a_beat_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(o_v_q) |-> ($past(st_q) == ST_IDLE || $past(st_q) == ST_REJ
                      || $past(st_q) == ST_EMIT))
    else $error("output beat from unexpected state");

  // an accepted first centre either restarts the seeding or is answered at once
  a_first_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_func == FN_FIRST) |=> (st_q == ST_CLR || o_v_q))
    else $error("first centre not handled");

  // the sweep never tags a point beyond those in use
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SWEEP && res_ctl.vld) |-> (res_j <= n_last))
    else $error("sweep index out of range");

endmodule
